>>> rtl/srt_pkg.sv
// Shared constants and types for the sorted region table.
// No dependencies.
package srt_pkg;
    localparam int MAX_REGIONS = 16;
    localparam int PAGE_SHIFT  = 12;
    localparam int IDX_W  = $clog2(MAX_REGIONS);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int SP_W   = 32 - PAGE_SHIFT;
    localparam int EP_W   = 33 - PAGE_SHIFT;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOTFD = 2'd3;

    typedef struct packed {
        logic [SP_W-1:0] sp;
        logic [EP_W-1:0] ep;
        logic [7:0]      kind;
        logic [7:0]      prot;
        logic            file;
        logic [15:0]     handle;
        logic [31:0]     offset;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic            ins;   // insert at/after key
        logic            del;   // delete matched cell, shift up
        logic            clr;
        logic [SP_W-1:0] key_sp;
        logic [EP_W-1:0] key_ep;
        logic [31:0]     probe;
    } t_bcast;

    // per-cell status back to the controller
    typedef struct packed {
        logic valid;
        logic overlap;
        logic hit;
        logic below;    // start page below key: new region goes after
    } t_cstat;
endpackage

>>> rtl/srt_cell.sv
// One slot of the region table: holds an entry, compares it with the
// broadcast key, and shifts with its neighbors on insert or delete.
// Depends on srt_pkg.
module srt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srt_pkg::t_bcast i_bc,
    input  srt_pkg::t_entry i_new,
    input  logic            i_prev_valid,
    input  logic            i_prev_before,
    input  srt_pkg::t_entry i_prev,
    input  logic            i_next_valid,
    input  srt_pkg::t_entry i_next,
    input  logic            i_hit_above,
    output srt_pkg::t_cstat o_stat,
    output srt_pkg::t_entry o_entry,
    output logic            o_hit_or_past
);
    logic            r_valid;
    srt_pkg::t_entry r_entry;
    logic [32:0]     w_s, w_e, w_p;

    assign w_s = {r_entry.sp, {srt_pkg::PAGE_SHIFT{1'b0}}, 1'b0} >> 1;
    assign w_e = {r_entry.ep, {srt_pkg::PAGE_SHIFT{1'b0}}};
    assign w_p = {1'b0, i_bc.probe};

    assign o_stat.valid   = r_valid;
    assign o_stat.overlap = r_valid && ({1'b0, i_bc.key_sp} < r_entry.ep)
                            && (i_bc.key_ep > {1'b0, r_entry.sp});
    assign o_stat.hit     = r_valid && (w_p >= w_s) && (w_p < w_e);
    assign o_stat.below   = r_valid && (r_entry.sp < i_bc.key_sp);
    // first hit wins; cells at or below it shift on delete
    assign o_hit_or_past  = o_stat.hit || i_hit_above;
    assign o_entry        = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_bc.clr) begin
            r_valid <= 1'b0;
        end else if (i_bc.ins) begin
            if (!o_stat.below) begin
                r_valid <= r_valid || i_prev_valid;
                r_entry <= i_prev_before ? i_new : i_prev;
            end
        end else if (i_bc.del) begin
            if (o_hit_or_past) begin
                r_valid <= i_next_valid;
                r_entry <= i_next;
            end
        end
    end
endmodule

>>> rtl/sorted_region_table.sv
// Sorted region table: a chain of cells kept in start-address order.
// Commands enter on the input channel, one status beat leaves per command.
// Depends on srt_pkg and srt_cell.
//
// Usage:
//   Input beat: i_cmd with address, end and region attributes; accepted when
//   i_valid is high and o_stall low. Output beat: o_status, o_slot and the
//   region fields, taken when o_valid is high and i_stall low.
//   Each command walks three states: the accepting edge registers the beat;
//   in the compare cycle all cells compare against the key in parallel and,
//   at its closing edge, the chain shifts (insert or delete) and the result
//   is captured; in the last state the result moves to the output register.
//   o_valid rises when that register is loaded on leaving the last state,
//   and a new command is taken only once the table is back in its idle
//   state, so no command is taken while the previous one is still in work.
//   A stalled result holds in the output register and holds off new input;
//   a command already in the chain waits in its last state until the output
//   register frees.
//   Reset empties the table at once (valid bits only) and clears the
//   channel state; no clearing pass is needed.
module sorted_region_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_addr,
    input  logic [31:0] i_end_addr,
    input  logic [7:0]  i_mem_kind,
    input  logic [7:0]  i_protection,
    input  logic        i_has_file,
    input  logic [15:0] i_file_handle,
    input  logic signed [31:0] i_offset_in_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [31:0] o_region_start,
    output logic [32:0] o_region_end,
    output logic [7:0]  o_region_mem_kind,
    output logic [7:0]  o_region_protection,
    output logic        o_region_has_file,
    output logic [15:0] o_region_file_handle,
    output logic signed [31:0] o_region_file_offset
);
    localparam int N = srt_pkg::MAX_REGIONS;
    localparam int PS = srt_pkg::PAGE_SHIFT;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [1:0]            r_cmd;
    logic [31:0]           r_addr;
    logic                  r_empty;
    srt_pkg::t_entry       r_new;
    logic [srt_pkg::CNT_W-1:0] r_count;

    srt_pkg::t_bcast       w_bc;
    srt_pkg::t_cstat       w_stat   [N];
    srt_pkg::t_entry       w_entry  [N];
    logic                  w_hop    [N];
    logic [N-1:0]          w_ovl, w_hit, w_before;

    logic                  r_ovalid;
    logic [1:0]            r_status;
    logic [3:0]            r_slot;
    srt_pkg::t_entry       r_res;
    logic                  r_has;

    // add key computation at accept
    logic [32:0]           w_eround;
    assign w_eround = {1'b0, i_end_addr} + {{(33-PS){1'b0}}, {PS{1'b1}}};

    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd   <= i_cmd;
            r_addr  <= i_addr;
            r_empty <= i_addr >= i_end_addr;
            r_new.sp     <= i_addr[31:PS];
            r_new.ep     <= w_eround[32:PS];
            r_new.kind   <= i_mem_kind;
            r_new.prot   <= i_protection;
            r_new.file   <= i_has_file;
            r_new.handle <= i_has_file ? i_file_handle : 16'd0;
            r_new.offset <= i_has_file ?
                i_offset_in_file - {{(32-PS){1'b0}}, i_addr[PS-1:0]} : i_offset_in_file;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            srt_cell u_cell (
                .i_clk              (i_clk),
                .i_rst_n            (i_rst_n),
                .i_bc               (w_bc),
                .i_new              (r_new),
                .i_prev_valid       ((g == 0) ? 1'b1 : w_stat[(g == 0) ? 0 : g-1].valid),
                .i_prev_before      ((g == 0) ? 1'b1 : w_stat[(g == 0) ? 0 : g-1].below),
                .i_prev             (w_entry[(g == 0) ? 0 : g-1]),
                .i_next_valid       ((g == N-1) ? 1'b0 : w_stat[(g == N-1) ? g : g+1].valid),
                .i_next             (w_entry[(g == N-1) ? g : g+1]),
                .i_hit_above        ((g == 0) ? 1'b0 : w_hop[(g == 0) ? 0 : g-1]),
                .o_stat             (w_stat[g]),
                .o_entry            (w_entry[g]),
                .o_hit_or_past      (w_hop[g])
            );
            assign w_ovl[g]    = w_stat[g].overlap;
            assign w_hit[g]    = w_stat[g].hit;
            assign w_before[g] = w_stat[g].below;
        end
    endgenerate

    // decide in S_CMP; chain acts on the same edge
    logic                        w_full, w_ok;
    logic [srt_pkg::IDX_W-1:0]   w_hidx;
    logic [srt_pkg::CNT_W-1:0]   w_pos;
    logic                        w_found;
    always_comb begin
        w_hidx  = '0;
        w_found = 1'b0;
        w_pos   = '0;
        for (int k = N-1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_hidx  = srt_pkg::IDX_W'(k);
                w_found = 1'b1;
            end
        end
        for (int k = 0; k < N; k++) begin
            w_pos = w_pos + srt_pkg::CNT_W'(w_before[k]);
        end
    end
    assign w_full = r_count >= srt_pkg::CNT_W'(N);
    assign w_ok   = !r_empty && (w_ovl == '0) && !w_full;

    always_comb begin
        w_bc.ins    = (r_state == S_CMP) && (r_cmd == srt_pkg::CMD_ADD) && w_ok;
        w_bc.del    = (r_state == S_CMP) && (r_cmd == srt_pkg::CMD_REMOVE) && w_found;
        w_bc.clr    = (r_state == S_CMP) && (r_cmd == srt_pkg::CMD_CLEAR);
        w_bc.key_sp = r_new.sp;
        w_bc.key_ep = r_new.ep;
        w_bc.probe  = r_addr;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && !o_stall) n_state = S_CMP;
            S_CMP:  n_state = S_DONE;
            S_DONE: if (!(r_ovalid && i_stall)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_bc.clr)      r_count <= '0;
            else if (w_bc.ins) r_count <= r_count + 1'b1;
            else if (w_bc.del) r_count <= r_count - 1'b1;
        end
    end

    // result computed in S_CMP, held until S_DONE hands it out
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            case (r_cmd)
                srt_pkg::CMD_ADD: begin
                    if (r_empty || (w_ovl != '0)) begin
                        r_status <= srt_pkg::ST_INVAL;
                        r_has    <= 1'b0;
                        r_slot   <= '0;
                    end else if (w_full) begin
                        r_status <= srt_pkg::ST_FULL;
                        r_has    <= 1'b0;
                        r_slot   <= '0;
                    end else begin
                        r_status <= srt_pkg::ST_OK;
                        r_has    <= 1'b1;
                        r_slot   <= 4'(w_pos);
                        r_res    <= r_new;
                    end
                end
                srt_pkg::CMD_LOOKUP, srt_pkg::CMD_REMOVE: begin
                    if (w_found) begin
                        r_status <= srt_pkg::ST_OK;
                        r_has    <= 1'b1;
                        r_slot   <= 4'(w_hidx);
                        r_res    <= w_entry[w_hidx];
                    end else begin
                        r_status <= srt_pkg::ST_NOTFD;
                        r_has    <= 1'b0;
                        r_slot   <= '0;
                    end
                end
                default: begin
                    r_status <= srt_pkg::ST_OK;
                    r_has    <= 1'b0;
                    r_slot   <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && !(r_ovalid && i_stall)) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register loaded on leaving S_DONE
    logic [1:0]      r_ost;
    logic [3:0]      r_osl;
    srt_pkg::t_entry r_ores;
    logic            r_ohas;
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && !(r_ovalid && i_stall)) begin
            r_ost  <= r_status;
            r_osl  <= r_slot;
            r_ores <= r_res;
            r_ohas <= r_has;
        end
    end

    assign o_valid              = r_ovalid;
    assign o_status             = r_ost;
    assign o_slot               = r_ohas ? r_osl : 4'd0;
    assign o_region_start       = r_ohas ? {r_ores.sp, {PS{1'b0}}} : 32'd0;
    assign o_region_end         = r_ohas ? {r_ores.ep, {PS{1'b0}}} : 33'd0;
    assign o_region_mem_kind    = r_ohas ? r_ores.kind : 8'd0;
    assign o_region_protection  = r_ohas ? r_ores.prot : 8'd0;
    assign o_region_has_file    = r_ohas ? r_ores.file : 1'b0;
    assign o_region_file_handle = r_ohas ? r_ores.handle : 16'd0;
    assign o_region_file_offset = r_ohas ? r_ores.offset : 32'sd0;
endmodule

>>> rtl/srt_checker.sv
// Port-level checks for the sorted region table.
// Depends on srt_pkg; bound to sorted_region_table.
module srt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_slot,
    input logic [32:0] o_region_end
);
    // a held result beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");
    // accepted beat blocks the next for the work cycles
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second beat taken while busy");
    // failures carry no region
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != srt_pkg::ST_OK |-> o_slot == 4'd0 && o_region_end == 33'd0)
        else $error("failure with region data");
    // no early result: o_valid stays low after an accept with the output idle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result too early");
endmodule

bind sorted_region_table srt_checker u_srt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_slot(o_slot), .o_region_end(o_region_end)
);

>>> bench/sorted_region_table_chk.sv
// Checker for the sorted region table: watches both channels, keeps a shadow
// region table, predicts each result beat and compares it. Depends on srt_pkg.
module sorted_region_table_chk
    import srt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_addr,
    input  logic [31:0] i_end_addr,
    input  logic [7:0]  i_mem_kind,
    input  logic [7:0]  i_protection,
    input  logic        i_has_file,
    input  logic [15:0] i_file_handle,
    input  logic [31:0] i_offset_in_file,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_region_start,
    input  logic [32:0] i_region_end,
    input  logic [7:0]  i_region_mem_kind,
    input  logic [7:0]  i_region_protection,
    input  logic        i_region_has_file,
    input  logic [15:0] i_region_file_handle,
    input  logic [31:0] i_region_file_offset,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] start;
        logic [32:0] stop;
        logic [7:0]  kind;
        logic [7:0]  prot;
        logic        file;
        logic [15:0] handle;
        logic [31:0] offset;
    } t_result;

    t_entry  regions [MAX_REGIONS];
    int      region_count;
    t_result expected_results[$];

    function automatic t_result region_result(logic [1:0] st, int idx);
        t_result r;
        r = '0;
        r.status = st;
        r.slot   = idx[3:0];
        r.start  = {regions[idx].sp, {PAGE_SHIFT{1'b0}}};
        r.stop   = {regions[idx].ep, {PAGE_SHIFT{1'b0}}};
        r.kind   = regions[idx].kind;
        r.prot   = regions[idx].prot;
        r.file   = regions[idx].file;
        r.handle = regions[idx].handle;
        r.offset = regions[idx].offset;
        return r;
    endfunction

    function automatic int find_region(logic [31:0] a);
        for (int i = 0; i < region_count; i++)
            if ({1'b0, a} >= {1'b0, regions[i].sp, {PAGE_SHIFT{1'b0}}} &&
                {1'b0, a} < {regions[i].ep, {PAGE_SHIFT{1'b0}}})
                return i;
        return -1;
    endfunction

    function automatic t_result apply_command();
        t_result     r;
        logic [32:0] ep_full;
        t_entry      n;
        int          pos;
        int          f;
        r = '0;
        case (i_cmd)
            CMD_ADD: begin
                if (i_addr >= i_end_addr) begin
                    r.status = ST_INVAL;
                    return r;
                end
                ep_full = {1'b0, i_end_addr} + (33'd1 << PAGE_SHIFT) - 33'd1;
                n.sp = i_addr[31:PAGE_SHIFT];
                n.ep = ep_full[32:PAGE_SHIFT];
                for (int i = 0; i < region_count; i++)
                    if (n.sp < regions[i].ep && n.ep > regions[i].sp) begin
                        r.status = ST_INVAL;
                        return r;
                    end
                if (region_count >= MAX_REGIONS) begin
                    r.status = ST_FULL;
                    return r;
                end
                n.kind   = i_mem_kind;
                n.prot   = i_protection;
                n.file   = i_has_file;
                n.handle = i_has_file ? i_file_handle : 16'd0;
                n.offset = i_has_file ?
                    i_offset_in_file - {{(32-PAGE_SHIFT){1'b0}}, i_addr[PAGE_SHIFT-1:0]}
                    : i_offset_in_file;
                pos = 0;
                while (pos < region_count && regions[pos].sp < n.sp)
                    pos++;
                for (int i = region_count; i > pos; i--)
                    regions[i] = regions[i-1];
                regions[pos] = n;
                region_count++;
                return region_result(ST_OK, pos);
            end
            CMD_LOOKUP: begin
                f = find_region(i_addr);
                if (f < 0) r.status = ST_NOTFD;
                else r = region_result(ST_OK, f);
                return r;
            end
            CMD_REMOVE: begin
                f = find_region(i_addr);
                if (f < 0) begin
                    r.status = ST_NOTFD;
                    return r;
                end
                r = region_result(ST_OK, f);
                for (int i = f; i + 1 < region_count; i++)
                    regions[i] = regions[i+1];
                region_count--;
                return r;
            end
            default: begin
                region_count = 0;
                return r;
            end
        endcase
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            region_count = 0;
            expected_results.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_slot, i_region_start, i_region_end,
                       i_region_mem_kind, i_region_protection, i_region_has_file,
                       i_region_file_handle, i_region_file_offset};
                o_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $realtime, got);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.start !== want.start || got.stop !== want.stop ||
                        got.kind !== want.kind || got.prot !== want.prot ||
                        got.file !== want.file || got.handle !== want.handle ||
                        got.offset !== want.offset) begin
                        $display("%0t: mismatch expected st=%0d slot=%0d %h..%h k=%h p=%h f=%b h=%h o=%h",
                                 $realtime, want.status, want.slot, want.start, want.stop,
                                 want.kind, want.prot, want.file, want.handle, want.offset);
                        $display("%0t:          actual   st=%0d slot=%0d %h..%h k=%h p=%h f=%b h=%h o=%h",
                                 $realtime, got.status, got.slot, got.start, got.stop,
                                 got.kind, got.prot, got.file, got.handle, got.offset);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                expected_results.push_back(apply_command());
        end
    end
endmodule

>>> bench/sorted_region_table_tb.sv
// Top of the sorted region table bench: clock, reset, command stimulus and
// the verdict. Depends on srt_pkg, sorted_region_table and the checker.
module sorted_region_table_tb;
    import srt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_CLEAR;
    logic [31:0] addr = '0;
    logic [31:0] end_addr = '0;
    logic [7:0]  mem_kind = '0;
    logic [7:0]  protection = '0;
    logic        has_file = 1'b0;
    logic [15:0] file_handle = '0;
    logic [31:0] offset_in_file = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] region_start;
    logic [32:0] region_end;
    logic [7:0]  region_mem_kind;
    logic [7:0]  region_protection;
    logic        region_has_file;
    logic [15:0] region_file_handle;
    logic [31:0] region_file_offset;
    int          errors;
    int          pending;
    int          results;
    int          cycles = 0;
    int          sent = 0;
    bit          calm = 1'b0;
    logic [31:0] used_addrs[$];

    always #5 clk = ~clk;

    sorted_region_table u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_cmd(cmd), .i_addr(addr), .i_end_addr(end_addr), .i_mem_kind(mem_kind),
        .i_protection(protection), .i_has_file(has_file),
        .i_file_handle(file_handle), .i_offset_in_file(offset_in_file),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status), .o_slot(slot),
        .o_region_start(region_start), .o_region_end(region_end),
        .o_region_mem_kind(region_mem_kind), .o_region_protection(region_protection),
        .o_region_has_file(region_has_file),
        .o_region_file_handle(region_file_handle),
        .o_region_file_offset(region_file_offset)
    );

    sorted_region_table_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_cmd(cmd), .i_addr(addr), .i_end_addr(end_addr), .i_mem_kind(mem_kind),
        .i_protection(protection), .i_has_file(has_file),
        .i_file_handle(file_handle), .i_offset_in_file(offset_in_file),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_slot(slot), .i_region_start(region_start), .i_region_end(region_end),
        .i_region_mem_kind(region_mem_kind), .i_region_protection(region_protection),
        .i_region_has_file(region_has_file),
        .i_region_file_handle(region_file_handle),
        .i_region_file_offset(region_file_offset),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL sorted_region_table");
            $finish;
        end
    end

    // receiver stalls about 36% of the time except in the calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 36);

    // one beat; valid drops only when the next beat is not ready at once
    task automatic send_cmd(logic [1:0] c, logic [31:0] a, logic [31:0] e);
        if (!calm)
            while ($urandom_range(99) < 36) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid       <= 1'b1;
        cmd            <= c;
        addr           <= a;
        end_addr       <= e;
        mem_kind       <= $urandom();
        protection     <= $urandom();
        has_file       <= $urandom_range(1);
        file_handle    <= $urandom();
        offset_in_file <= $urandom();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // small regions inside a few megabytes so that adds, hits and overlaps mix
    task automatic random_cmd();
        logic [31:0] a;
        int          pick;
        pick = $urandom_range(99);
        a = ($urandom_range(99) < 80) ? $urandom_range(32'h003F_FFFF) : $urandom();
        if (pick < 50) begin
            used_addrs.push_back(a);
            send_cmd(CMD_ADD, a, a + $urandom_range(1, 32'h6000));
        end else if (pick < 55) begin
            send_cmd(CMD_ADD, a, $urandom());
        end else if (pick < 98) begin
            if (used_addrs.size() > 0 && $urandom_range(1))
                a = used_addrs[$urandom_range(used_addrs.size() - 1)]
                    + $urandom_range(32'h1FFF);
            send_cmd(pick < 78 ? CMD_LOOKUP : CMD_REMOVE, a, $urandom());
        end else begin
            send_cmd(CMD_CLEAR, a, $urandom());
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty range, extremes, file offset, end at top, overlap
        send_cmd(CMD_LOOKUP, 32'h0, 32'h0);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_cmd(CMD_ADD, 32'h5000, 32'h5000);
        send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'h0);
        send_cmd(CMD_ADD, 32'h0000_0FFF, 32'h0000_1001);
        send_cmd(CMD_ADD, 32'hFFFF_F123, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 32'h0000_1800, 32'h0000_2000);
        send_cmd(CMD_ADD, 32'h8000_0000, 32'h8000_0001);
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_cmd(CMD_LOOKUP, 32'h0000_1FFF, 32'h0);
        send_cmd(CMD_REMOVE, 32'h0000_0000, 32'h0);
        send_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        for (int i = 0; i < 17; i++)
            send_cmd(CMD_ADD, 32'h1000_0000 + i * 32'h10000, 32'h1000_0FFF + i * 32'h10000);
        send_cmd(CMD_REMOVE, 32'h1005_0000, 32'h0);
        send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int n = 0; n < 500; n++) begin
            calm = (n >= 200 && n < 280);
            random_cmd();
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("sent %0d commands, checked %0d results (adds, hits, overlaps, full, clears)",
                 sent, results);
        if (errors == 0)
            $display("PASS sorted_region_table");
        else
            $display("FAIL sorted_region_table");
        $finish;
    end
endmodule
